>>> hdl/oil_pkg.sv
`timescale 1ns / 1ps

package oil_pkg;

  localparam int WORD_BITS    = 64;
  localparam int CHUNK_BITS   = 8;
  localparam int CHUNKS       = WORD_BITS / CHUNK_BITS;
  localparam int CHUNK_IDX_W  = $clog2(CHUNKS);
  localparam int BIT_IDX_W    = $clog2(CHUNK_BITS);
  localparam int ORB_W        = 8;
  localparam int CNT_W        = 9;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 9;
  localparam int MAX_WORDS_DEF = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_LIST_KIND     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERLEAVE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORBITAL_COUNT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_MARK = 3'b100
  } state_t;

  // lowest set bit of one chunk (0 for an empty chunk)
  function automatic logic [BIT_IDX_W-1:0] lowest_bit(input logic [CHUNK_BITS-1:0] c);
    logic [BIT_IDX_W-1:0] n;
    n = '0;
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      if (c[i]) n = BIT_IDX_W'(i);
    end
    return n;
  endfunction

endpackage

>>> hdl/orbital_index_lister.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// in_       in   in_valid/in_stall    occupation_word[63:0], word_last
// out_      out  out_valid/out_stall  orbital, slot, entry_valid, list_end, total_entries
// cfg_      in   cfg_wr_en            cfg_index[1:0], cfg_data[8:0]
//
// Each word is loaded, then scanned chunk by chunk: an 8-bit chunk that holds no
// remaining bit moves the scan on to the next chunk, and each set bit is listed in turn.
// Unless out_stall holds it, the scan unit looks at a single chunk per cycle and emits
// at most one entry per cycle; a final word with nothing to list gets a bare end marker.
// Reset (rst_n low, synchronous) clears the counters, the FSM and the config to
// list_kind 0, interleave 0, orbital_count 256. in_stall stays high while a word is
// being scanned; out_stall simply holds the scan until the output register frees up.

module orbital_index_lister #(
  parameter int MAX_WORDS = oil_pkg::MAX_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [oil_pkg::WORD_BITS-1:0] in_occupation_word,
  input  logic                          in_word_last,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [oil_pkg::ORB_W-1:0]     out_orbital,
  output logic [oil_pkg::ORB_W-1:0]     out_slot,
  output logic                          out_entry_valid,
  output logic                          out_list_end,
  output logic [oil_pkg::CNT_W-1:0]     out_total_entries,
  // config port
  input  logic                          cfg_wr_en,
  input  logic [oil_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [oil_pkg::CFG_DATA_W-1:0] cfg_data
);
  import oil_pkg::*;

  localparam int WI_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam logic [WI_W-1:0] WI_LAST = WI_W'(MAX_WORDS - 1);

  // config registers
  logic             list_kind_r;
  logic             interleave_r;
  logic [CNT_W-1:0] orbital_count_r;

  // list state
  state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0] w_r, w_nxt;
  logic                 last_r, last_nxt;
  logic [CHUNK_IDX_W-1:0] chunk_r, chunk_nxt;
  logic [WI_W-1:0]      word_index_r, word_index_nxt;
  logic [CNT_W-1:0]     entry_count_r, entry_count_nxt;
  logic [ORB_W-1:0]     alpha_count_r, alpha_count_nxt;
  logic [ORB_W-1:0]     beta_count_r, beta_count_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [ORB_W-1:0] orbital_r, orbital_nxt;
  logic [ORB_W-1:0] slot_r, slot_nxt;
  logic             entry_valid_r, entry_valid_nxt;
  logic             list_end_r, list_end_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;

  // load path: invert and mask in virtual mode
  logic                 in_accept;
  logic [5:0]           rem;
  logic [WORD_BITS-1:0] keep_mask;
  logic [WORD_BITS-1:0] w_load;

  // scan datapath
  logic                   out_free;
  logic [CHUNK_BITS-1:0]  chunk_bits;
  logic [CHUNK_BITS-1:0]  chunk_clr;
  logic [BIT_IDX_W-1:0]   bit_pos;
  logic [WORD_BITS-1:0]   w_clr;
  logic                   w_clr_any;
  logic [ORB_W-1:0]       wi_ext;
  logic [ORB_W-1:0]       orb;
  logic [CNT_W-1:0]       count_inc;
  logic [ORB_W-1:0]       alpha_inc;
  logic [ORB_W-1:0]       beta_inc;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign rem = orbital_count_r[5:0];

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      keep_mask[j] = (6'(j) < rem);
    end
  end

  always_comb begin
    w_load = in_occupation_word;
    if (list_kind_r) begin
      w_load = ~in_occupation_word;
      if (in_word_last && (rem != 6'd0)) w_load = w_load & keep_mask;
    end
  end

  // one chunk per cycle while the output is free: pick its lowest bit, clear it
  assign chunk_bits = w_r[chunk_r*CHUNK_BITS +: CHUNK_BITS];
  assign bit_pos    = lowest_bit(chunk_bits);
  assign chunk_clr  = chunk_bits & (chunk_bits - CHUNK_BITS'(1));

  always_comb begin
    w_clr = w_r;
    w_clr[chunk_r*CHUNK_BITS +: CHUNK_BITS] = chunk_clr;
  end
  assign w_clr_any = |w_clr;

  // orbital keeps only its low 8 bits, so two bits of word index reach it
  assign wi_ext    = ORB_W'(word_index_r);
  assign orb       = {wi_ext[1:0], chunk_r, bit_pos};
  assign count_inc = (entry_count_r == CNT_MAX) ? entry_count_r : entry_count_r + CNT_W'(1);
  assign alpha_inc = alpha_count_r + ORB_W'(1);
  assign beta_inc  = beta_count_r + ORB_W'(1);

  always_comb begin
    state_nxt       = state_r;
    w_nxt           = w_r;
    last_nxt        = last_r;
    chunk_nxt       = chunk_r;
    word_index_nxt  = word_index_r;
    entry_count_nxt = entry_count_r;
    alpha_count_nxt = alpha_count_r;
    beta_count_nxt  = beta_count_r;
    out_valid_nxt   = out_valid_r && out_stall;
    orbital_nxt     = orbital_r;
    slot_nxt        = slot_r;
    entry_valid_nxt = entry_valid_r;
    list_end_nxt    = list_end_r;
    total_nxt       = total_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          w_nxt     = w_load;
          last_nxt  = in_word_last;
          chunk_nxt = '0;
          if (|w_load) begin
            state_nxt = ST_SCAN;
          end else if (in_word_last) begin
            state_nxt = ST_MARK;
          end else begin
            // empty non-final word: nothing to emit
            word_index_nxt = (word_index_r == WI_LAST) ? '0 : word_index_r + WI_W'(1);
          end
        end
      end

      ST_SCAN: begin
        if (out_free) begin
          if (chunk_bits == '0) begin
            chunk_nxt = chunk_r + CHUNK_IDX_W'(1);
          end else begin
            w_nxt           = w_clr;
            entry_count_nxt = count_inc;
            out_valid_nxt   = 1'b1;
            orbital_nxt     = orb;
            entry_valid_nxt = 1'b1;
            list_end_nxt    = last_r && !w_clr_any;
            total_nxt       = count_inc;
            if (interleave_r) begin
              if (orb[0]) begin
                // beta: slot 2*beta_count+1
                beta_count_nxt = beta_inc;
                slot_nxt       = {beta_count_r[ORB_W-2:0], 1'b1};
              end else begin
                // alpha: slot 2*alpha_count
                alpha_count_nxt = alpha_inc;
                slot_nxt        = {alpha_count_r[ORB_W-2:0], 1'b0};
              end
            end else begin
              slot_nxt = entry_count_r[ORB_W-1:0];
            end
            if (!w_clr_any) begin
              state_nxt = ST_IDLE;
              if (last_r) begin
                word_index_nxt  = '0;
                entry_count_nxt = '0;
                alpha_count_nxt = '0;
                beta_count_nxt  = '0;
              end else begin
                word_index_nxt = (word_index_r == WI_LAST) ? '0 : word_index_r + WI_W'(1);
              end
            end
          end
        end
      end

      ST_MARK: begin
        // final word with nothing listed: bare end marker
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          orbital_nxt     = '0;
          slot_nxt        = '0;
          entry_valid_nxt = 1'b0;
          list_end_nxt    = 1'b1;
          total_nxt       = entry_count_r;
          word_index_nxt  = '0;
          entry_count_nxt = '0;
          alpha_count_nxt = '0;
          beta_count_nxt  = '0;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      word_index_r  <= '0;
      entry_count_r <= '0;
      alpha_count_r <= '0;
      beta_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      word_index_r  <= word_index_nxt;
      entry_count_r <= entry_count_nxt;
      alpha_count_r <= alpha_count_nxt;
      beta_count_r  <= beta_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    w_r           <= w_nxt;
    last_r        <= last_nxt;
    chunk_r       <= chunk_nxt;
    orbital_r     <= orbital_nxt;
    slot_r        <= slot_nxt;
    entry_valid_r <= entry_valid_nxt;
    list_end_r    <= list_end_nxt;
    total_r       <= total_nxt;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_kind_r     <= 1'b0;
      interleave_r    <= 1'b0;
      orbital_count_r <= CNT_W'(256);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LIST_KIND:     list_kind_r     <= cfg_data[0];
        REG_INTERLEAVE:    interleave_r    <= cfg_data[0];
        REG_ORBITAL_COUNT: orbital_count_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_orbital       = orbital_r;
  assign out_slot          = slot_r;
  assign out_entry_valid   = entry_valid_r;
  assign out_list_end      = list_end_r;
  assign out_total_entries = total_r;

endmodule
